// ===== hdl/vbpr_pkg.sv =====
`timescale 1ns / 1ps

package vbpr_pkg;

    // video memory geometry
    localparam int VIDEO_BYTES = 8192;
    localparam int ADDR_W      = $clog2(VIDEO_BYTES);
    localparam int OFF_W       = 13;
    localparam int TEXT_BYTES  = 512;
    localparam int TEXT_ROWS   = 12;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // palette indices
    localparam logic [1:0] PIX_BLACK = 2'd0;
    localparam logic [1:0] PIX_WHITE = 2'd3;

    // item types on the two channels
    typedef struct packed {
        logic [12:0] offset;
        logic [7:0]  data_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0]  row_y;
        logic [7:0]  row_x;
        logic [31:0] pixel_row;
        logic [4:0]  pixel_count;
        logic        last;
    } row_item_t;

    // one classified write, ready to be drawn
    typedef struct packed {
        logic        is_text;
        logic [7:0]  code;
        logic [7:0]  base_y;
        logic [7:0]  row_x;
        logic [31:0] pixel_row;
        logic [4:0]  pixel_count;
        logic [3:0]  last_row;
    } cmd_t;

    // graphics mode geometry
    typedef struct packed {
        logic        wide;    // 32 bytes per line, else 16
        logic        bpp2;    // 2 bits per pixel, else 1
        logic [1:0]  xsh;     // log2 of horizontal replication
        logic [1:0]  yrep;    // vertical replication
        logic [12:0] area;    // bytes in the active area
    } geom_t;

    function automatic geom_t mode_geom(input logic [2:0] mode);
        geom_t g;
        case (mode)
            3'd0:    g = '{wide: 1'b0, bpp2: 1'b1, xsh: 2'd2, yrep: 2'd3, area: 13'd1024};
            3'd1:    g = '{wide: 1'b0, bpp2: 1'b0, xsh: 2'd1, yrep: 2'd3, area: 13'd1024};
            3'd2:    g = '{wide: 1'b1, bpp2: 1'b1, xsh: 2'd1, yrep: 2'd3, area: 13'd2048};
            3'd3:    g = '{wide: 1'b0, bpp2: 1'b0, xsh: 2'd1, yrep: 2'd2, area: 13'd1536};
            3'd4:    g = '{wide: 1'b1, bpp2: 1'b1, xsh: 2'd1, yrep: 2'd2, area: 13'd3072};
            3'd5:    g = '{wide: 1'b0, bpp2: 1'b0, xsh: 2'd1, yrep: 2'd1, area: 13'd3072};
            3'd6:    g = '{wide: 1'b1, bpp2: 1'b1, xsh: 2'd1, yrep: 2'd1, area: 13'd6144};
            3'd7:    g = '{wide: 1'b1, bpp2: 1'b0, xsh: 2'd0, yrep: 2'd1, area: 13'd6144};
            default: g = '{wide: 1'b1, bpp2: 1'b0, xsh: 2'd0, yrep: 2'd1, area: 13'd6144};
        endcase
        return g;
    endfunction

    // 5x7 character glyphs, bit 4 leftmost
    localparam logic [4:0] GLYPH_ROM [64][7] = '{
        '{5'd14,5'd17,5'd1,5'd13,5'd21,5'd21,5'd14}, '{5'd4,5'd10,5'd17,5'd17,5'd31,5'd17,5'd17},
        '{5'd30,5'd9,5'd9,5'd14,5'd9,5'd9,5'd30},    '{5'd14,5'd17,5'd16,5'd16,5'd16,5'd17,5'd14},
        '{5'd30,5'd9,5'd9,5'd9,5'd9,5'd9,5'd30},     '{5'd31,5'd16,5'd16,5'd28,5'd16,5'd16,5'd31},
        '{5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd16}, '{5'd15,5'd16,5'd16,5'd19,5'd17,5'd17,5'd15},
        '{5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17}, '{5'd14,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14},
        '{5'd1,5'd1,5'd1,5'd17,5'd17,5'd10,5'd4},     '{5'd17,5'd18,5'd20,5'd24,5'd24,5'd20,5'd18},
        '{5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd31}, '{5'd17,5'd27,5'd21,5'd17,5'd17,5'd17,5'd17},
        '{5'd17,5'd25,5'd21,5'd19,5'd17,5'd17,5'd17}, '{5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14},
        '{5'd30,5'd17,5'd17,5'd30,5'd16,5'd16,5'd16}, '{5'd14,5'd17,5'd17,5'd17,5'd21,5'd18,5'd13},
        '{5'd30,5'd17,5'd17,5'd30,5'd20,5'd18,5'd17}, '{5'd14,5'd17,5'd8,5'd4,5'd2,5'd17,5'd14},
        '{5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4},       '{5'd17,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14},
        '{5'd17,5'd17,5'd17,5'd17,5'd10,5'd10,5'd4},  '{5'd17,5'd17,5'd17,5'd17,5'd21,5'd27,5'd17},
        '{5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17},  '{5'd17,5'd17,5'd10,5'd4,5'd4,5'd4,5'd4},
        '{5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd31},     '{5'd14,5'd8,5'd8,5'd8,5'd8,5'd8,5'd14},
        '{5'd16,5'd16,5'd8,5'd4,5'd2,5'd1,5'd1},      '{5'd14,5'd2,5'd2,5'd2,5'd2,5'd2,5'd14},
        '{5'd4,5'd14,5'd31,5'd4,5'd4,5'd4,5'd4},      '{5'd0,5'd4,5'd8,5'd31,5'd8,5'd4,5'd0},
        '{5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0},        '{5'd4,5'd4,5'd4,5'd4,5'd4,5'd0,5'd4},
        '{5'd10,5'd10,5'd0,5'd0,5'd0,5'd0,5'd0},      '{5'd10,5'd10,5'd27,5'd0,5'd27,5'd10,5'd10},
        '{5'd4,5'd15,5'd16,5'd14,5'd1,5'd30,5'd4},    '{5'd25,5'd25,5'd2,5'd4,5'd8,5'd19,5'd19},
        '{5'd8,5'd20,5'd20,5'd9,5'd22,5'd22,5'd9},    '{5'd4,5'd4,5'd0,5'd0,5'd0,5'd0,5'd0},
        '{5'd2,5'd4,5'd8,5'd8,5'd8,5'd4,5'd2},        '{5'd8,5'd4,5'd2,5'd2,5'd2,5'd4,5'd8},
        '{5'd0,5'd4,5'd14,5'd31,5'd14,5'd4,5'd0},     '{5'd0,5'd4,5'd4,5'd31,5'd4,5'd4,5'd0},
        '{5'd0,5'd0,5'd0,5'd6,5'd6,5'd2,5'd4},        '{5'd0,5'd0,5'd0,5'd31,5'd0,5'd0,5'd0},
        '{5'd0,5'd0,5'd0,5'd0,5'd0,5'd4,5'd4},        '{5'd1,5'd1,5'd2,5'd4,5'd8,5'd16,5'd16},
        '{5'd4,5'd10,5'd10,5'd10,5'd10,5'd10,5'd4},   '{5'd4,5'd12,5'd4,5'd4,5'd4,5'd4,5'd14},
        '{5'd14,5'd17,5'd1,5'd14,5'd16,5'd16,5'd31},  '{5'd14,5'd17,5'd1,5'd6,5'd1,5'd17,5'd14},
        '{5'd2,5'd6,5'd10,5'd31,5'd2,5'd2,5'd2},      '{5'd31,5'd16,5'd30,5'd1,5'd1,5'd17,5'd14},
        '{5'd14,5'd16,5'd16,5'd30,5'd17,5'd17,5'd14}, '{5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd16},
        '{5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14}, '{5'd14,5'd17,5'd17,5'd15,5'd1,5'd1,5'd14},
        '{5'd0,5'd0,5'd4,5'd0,5'd4,5'd0,5'd0},        '{5'd6,5'd6,5'd0,5'd6,5'd6,5'd2,5'd4},
        '{5'd2,5'd4,5'd8,5'd16,5'd8,5'd4,5'd2},       '{5'd0,5'd0,5'd31,5'd0,5'd31,5'd0,5'd0},
        '{5'd16,5'd8,5'd4,5'd2,5'd4,5'd8,5'd16},      '{5'd4,5'd10,5'd2,5'd4,5'd4,5'd0,5'd4}
    };

    // one pixel row of a text cell, r = 0..11
    function automatic logic [31:0] text_row(input logic [7:0] ch, input logic [3:0] r);
        logic [31:0] row;
        logic [4:0]  bits;
        logic [3:0]  r_glyph;
        logic [1:0]  bg;
        logic [1:0]  fg;
        logic [1:0]  wh;
        logic [1:0]  c;
        logic [1:0]  band;
        logic [2:0]  bit_idx;
        logic        on;
        row     = '0;
        bits    = '0;
        r_glyph = r - 4'd3;
        if (!ch[6])
        begin
            // glyph, inverse for the upper half of the codes
            bg = ch[7] ? PIX_WHITE : PIX_BLACK;
            fg = ~bg;
            if (r >= 4'd3 && r < 4'd10)
            begin
                bits = GLYPH_ROM[ch[5:0]][r_glyph[2:0]];
            end
            for (int p = 0; p < 8; p++)
            begin
                c = bg;
                if (p >= 2 && p < 7)
                begin
                    if (bits[6 - p])
                    begin
                        c = fg;
                    end
                end
                row[2*p +: 2] = c;
            end
        end
        else
        begin
            // semigraphic blocks, solid or patterned
            wh   = ch[7] ? PIX_BLACK : PIX_WHITE;
            band = r[3:2];
            for (int h = 0; h < 2; h++)
            begin
                bit_idx = 3'(5 - 2 * int'(band) - h);
                on      = ch[bit_idx];
                for (int p = 0; p < 4; p++)
                begin
                    c = PIX_BLACK;
                    if (on)
                    begin
                        c = (!r[0] && ((p & 1) == 0)) ? PIX_WHITE : wh;
                    end
                    row[2*(4*h + p) +: 2] = c;
                end
            end
        end
        return row;
    endfunction

    // one replicated pixel row of a graphics byte
    function automatic logic [31:0] gfx_row(input geom_t g, input logic [7:0] b);
        logic [31:0] row;
        logic [1:0]  c;
        int          k;
        int          cnt;
        row = '0;
        cnt = g.wide ? 8 : 16;
        for (int p = 0; p < 16; p++)
        begin
            if (p < cnt)
            begin
                k = p >> g.xsh;
                if (g.bpp2)
                begin
                    c = b[7 - 2*k -: 2];
                end
                else
                begin
                    c = b[7 - k] ? PIX_WHITE : PIX_BLACK;
                end
                row[2*p +: 2] = c;
            end
        end
        return row;
    endfunction

endpackage

// ===== hdl/video_byte_pixel_renderer_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_item_t  (offset, data_byte)
// row       out        row_valid / row_ready  row_item_t  (row_y .. last)
// mode      in         mode_we                mode_data   (display_mode, signed)
//
// A write enters at one item per cycle while req_ready is high; the shadow memory
// is read at the accepting edge, the write is compared and classified in the next
// cycle and pushed into the queue once it has room; its rows go from the queue head
// to the output register. The row generator emits one row per cycle unless row_ready
// stalls it: 12 rows for a text write, 1 to 3 for a graphics write; it sets the
// sustained rate for repainting writes. After reset the shadow memory is cleared one
// byte a cycle, all 8192 bytes, with req_ready low; mode writes are taken throughout.
// A stalled row output fills the two-entry queue; the next repainting write then
// waits in the compare stage and holds req_ready low.

module video_byte_pixel_renderer_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  vbpr_pkg::req_item_t req,
    output logic                row_valid,
    input  logic                row_ready,
    output vbpr_pkg::row_item_t row,
    input  logic                mode_we,
    input  logic signed [3:0]   mode_data
);

    logic           push;
    vbpr_pkg::cmd_t push_cmd;
    logic           q_ready;
    logic           head_valid;
    vbpr_pkg::cmd_t head_cmd;
    logic           pop;

    // compare against shadow memory and classify
    vbpr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .mode_we   (mode_we),
        .mode_data (mode_data),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_ready   (q_ready)
    );

    // command queue
    vbpr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_ready    (q_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // row generation
    vbpr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .row_valid  (row_valid),
        .row_ready  (row_ready),
        .row        (row)
    );

endmodule

// ===== hdl/vbpr_front.sv =====
`timescale 1ns / 1ps

module vbpr_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  vbpr_pkg::req_item_t req,
    input  logic                mode_we,
    input  logic signed [3:0]   mode_data,
    output logic                push,
    output vbpr_pkg::cmd_t      push_cmd,
    input  logic                q_ready
);

    // shadow copy of video memory
    logic [7:0] mem [vbpr_pkg::VIDEO_BYTES];

    logic signed [3:0]                 mode_reg;
    logic                              clr_active_reg;
    logic [vbpr_pkg::ADDR_W-1:0]       clr_addr_reg;
    logic                              s1_valid_reg;
    vbpr_pkg::req_item_t               s1_item_reg;
    logic [7:0]                        rd_data_reg;
    logic                              byp_hit_reg;
    logic [7:0]                        byp_data_reg;

    logic                              accept;
    logic [7:0]                        old_byte;
    logic                              in_range;
    logic                              changed;
    logic                              in_area;
    logic                              emit;
    logic                              s1_adv;
    logic                              s1_wr;
    logic                              mem_we;
    logic [vbpr_pkg::ADDR_W-1:0]       mem_wa;
    logic [7:0]                        mem_wd;
    vbpr_pkg::geom_t                   geom;
    logic [7:0]                        line;
    logic [9:0]                        gfx_y;
    logic [7:0]                        text_y;

    assign accept = req_valid && req_ready;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= -4'sd1;
        end
        else if (mode_we)
        begin
            mode_reg <= mode_data;
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == vbpr_pkg::ADDR_W'(vbpr_pkg::VIDEO_BYTES - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // memory port
    assign mem_we = clr_active_reg || s1_wr;
    assign mem_wa = clr_active_reg ? clr_addr_reg
                                   : s1_item_reg.offset[vbpr_pkg::ADDR_W-1:0];
    assign mem_wd = clr_active_reg ? 8'd0 : s1_item_reg.data_byte;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (accept)
        begin
            rd_data_reg <= mem[req.offset[vbpr_pkg::ADDR_W-1:0]];
        end
    end

    // compare stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                byp_hit_reg  <= s1_wr && (s1_item_reg.offset == req.offset);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= req;
            byp_data_reg <= s1_item_reg.data_byte;
        end
    end

    // a write in the read cycle is not yet in the read data
    assign old_byte = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign in_range = 14'(s1_item_reg.offset) < 14'(vbpr_pkg::VIDEO_BYTES);
    assign changed  = in_range && (old_byte != s1_item_reg.data_byte);

    // classify the write
    assign geom   = vbpr_pkg::mode_geom(mode_reg[2:0]);
    assign line   = geom.wide ? s1_item_reg.offset[12:5] : s1_item_reg.offset[11:4];
    assign gfx_y  = 10'(line) * 10'(geom.yrep);
    assign text_y = {4'd0, s1_item_reg.offset[8:5]} * 8'(vbpr_pkg::TEXT_ROWS);

    always_comb
    begin
        push_cmd      = '0;
        push_cmd.code = s1_item_reg.data_byte;
        if (mode_reg[3])
        begin
            in_area              = s1_item_reg.offset < 13'(vbpr_pkg::TEXT_BYTES);
            push_cmd.is_text     = 1'b1;
            push_cmd.base_y      = text_y;
            push_cmd.row_x       = {s1_item_reg.offset[4:0], 3'd0};
            push_cmd.pixel_count = 5'd8;
            push_cmd.last_row    = 4'(vbpr_pkg::TEXT_ROWS - 1);
        end
        else
        begin
            in_area              = s1_item_reg.offset < geom.area;
            push_cmd.is_text     = 1'b0;
            push_cmd.base_y      = gfx_y[7:0];
            push_cmd.row_x       = geom.wide ? {s1_item_reg.offset[4:0], 3'd0}
                                             : {s1_item_reg.offset[3:0], 4'd0};
            push_cmd.pixel_row   = vbpr_pkg::gfx_row(geom, s1_item_reg.data_byte);
            push_cmd.pixel_count = geom.wide ? 5'd8 : 5'd16;
            push_cmd.last_row    = {2'd0, geom.yrep - 2'd1};
        end
    end

    // handoff to the queue
    assign emit      = changed && in_area;
    assign s1_adv    = s1_valid_reg && (!emit || q_ready);
    assign s1_wr     = s1_adv && changed;
    assign push      = s1_adv && emit;
    assign req_ready = !clr_active_reg && (!s1_valid_reg || s1_adv);

endmodule

// ===== hdl/vbpr_queue.sv =====
`timescale 1ns / 1ps

module vbpr_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vbpr_pkg::cmd_t push_cmd,
    output logic           q_ready,
    output logic           head_valid,
    output vbpr_pkg::cmd_t head_cmd,
    input  logic           pop
);

    vbpr_pkg::cmd_t                  slot_reg [vbpr_pkg::Q_DEPTH];
    logic [vbpr_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [vbpr_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [vbpr_pkg::Q_CNT_W-1:0]    cnt_reg;
    logic [vbpr_pkg::Q_CNT_W-1:0]    cnt_next;

    assign q_ready    = cnt_reg != vbpr_pkg::Q_CNT_W'(vbpr_pkg::Q_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == vbpr_pkg::Q_PTR_W'(vbpr_pkg::Q_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == vbpr_pkg::Q_PTR_W'(vbpr_pkg::Q_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/vbpr_back.sv =====
`timescale 1ns / 1ps

module vbpr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  vbpr_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic                row_valid,
    input  logic                row_ready,
    output vbpr_pkg::row_item_t row
);

    logic [3:0]          row_cnt_reg;
    logic                out_valid_reg;
    vbpr_pkg::row_item_t out_item_reg;
    logic                issue;
    logic                last_row;
    vbpr_pkg::row_item_t item_next;

    assign issue    = head_valid && (!out_valid_reg || row_ready);
    assign last_row = row_cnt_reg == head_cmd.last_row;
    assign pop      = issue && last_row;

    // build the current row
    always_comb
    begin
        item_next.row_y       = head_cmd.base_y + {4'd0, row_cnt_reg};
        item_next.row_x       = head_cmd.row_x;
        item_next.pixel_row   = head_cmd.is_text
                                ? vbpr_pkg::text_row(head_cmd.code, row_cnt_reg)
                                : head_cmd.pixel_row;
        item_next.pixel_count = head_cmd.pixel_count;
        item_next.last        = last_row;
    end

    // row counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                row_cnt_reg   <= last_row ? 4'd0 : row_cnt_reg + 4'd1;
                out_valid_reg <= 1'b1;
            end
            else if (row_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            out_item_reg <= item_next;
        end
    end

    assign row_valid = out_valid_reg;
    assign row       = out_item_reg;

endmodule

// ===== hdl/vbpr_checker.sv =====
`timescale 1ns / 1ps

module vbpr_row_props
(
    input logic                clk,
    input logic                rst_n,
    input logic                row_valid,
    input logic                row_ready,
    input vbpr_pkg::row_item_t row
);

    // a stalled row item holds
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_ready |=> row_valid && $stable(row))
        else $error("row item changed while stalled");

    // pixel count is 8 or 16
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (row.pixel_count == 5'd8 || row.pixel_count == 5'd16))
        else $error("bad pixel count");

    // unused pixels are zero in 8-pixel rows
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row.pixel_count == 5'd8 |-> row.pixel_row[31:16] == 16'd0)
        else $error("pixels beyond count not zero");

    // rows stay on screen and 16-pixel rows are aligned
    a_place: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> row.row_y < 8'd192
                      && (row.pixel_count != 5'd16 || row.row_x[3:0] == 4'd0))
        else $error("row placed off screen");

endmodule

bind video_byte_pixel_renderer_unit vbpr_row_props u_chk (.*);
